// ===== rtl/box_blur_3x3_edge_aware_macros.svh =====
// Assertion macros used by the blur top level
`ifndef BOX_BLUR_3X3_EDGE_AWARE_MACROS_SVH
`define BOX_BLUR_3X3_EDGE_AWARE_MACROS_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define BB3_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while arst_n is low
`define BB3_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/bb3_pkg.sv =====
// Types, constants and the reciprocal table of the 3x3 box blur
`default_nettype none

package bb3_pkg;

	localparam int FW_W        = 11;
	localparam int FH_W        = 13;
	localparam int CFG_W       = 13;
	localparam int CH_W        = 8;
	localparam int CSUM_W      = 10;
	localparam int SUM_W       = 12;
	localparam int X_W         = 13;
	localparam int N_W         = 4;
	localparam int RECIP_W     = 20;
	localparam int RECIP_SHIFT = 20;
	localparam int PROD_W      = X_W + RECIP_W;

	localparam logic [FW_W-1:0] FW_RESET = 11'd640;
	localparam logic [FH_W-1:0] FH_RESET = 13'd480;

	localparam logic REQ_PIXEL = 1'b0;
	localparam logic REQ_DRAIN = 1'b1;

	typedef enum logic {
		REG_FRAME_WIDTH  = 1'b0,
		REG_FRAME_HEIGHT = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic            req_type;
		logic [CH_W-1:0] red;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] blue;
	} bb3_in_t;

	typedef struct packed {
		logic [CH_W-1:0] out_red;
		logic [CH_W-1:0] out_green;
		logic [CH_W-1:0] out_blue;
		logic            end_of_row;
		logic            end_of_frame;
	} bb3_out_t;

	typedef struct packed {
		logic [CH_W-1:0] red;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] blue;
	} rgb_t;

	// index 0 = upper row, 1 = middle row, 2 = current row
	typedef rgb_t [2:0] col_t;

	typedef struct packed {
		logic [CSUM_W-1:0] red;
		logic [CSUM_W-1:0] green;
		logic [CSUM_W-1:0] blue;
	} colsum_t;

	typedef struct packed {
		logic       shift;
		logic [2:0] rmask;
	} cell_ctl_t;

	// ceil(2^20 / (2*n)) for a count of n neighbors
	function automatic logic [RECIP_W-1:0] recip(input logic [N_W-1:0] n);
		logic [RECIP_W-1:0] r;
		case (n)
			4'd1:    r = 20'd524288;
			4'd2:    r = 20'd262144;
			4'd3:    r = 20'd174763;
			4'd4:    r = 20'd131072;
			4'd5:    r = 20'd104858;
			4'd6:    r = 20'd87382;
			4'd7:    r = 20'd74899;
			4'd8:    r = 20'd65536;
			4'd9:    r = 20'd58255;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/bb3_ram.sv =====
// Generic single-write, single-read RAM with registered read data
`default_nettype none

module bb3_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 1024,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/bb3_cell.sv =====
// One window column cell: holds three pixels, passes them left, sums its rows
`default_nettype none

module bb3_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  bb3_pkg::cell_ctl_t ctl,
	input  bb3_pkg::col_t      col_in,
	output bb3_pkg::col_t      col_out,
	output bb3_pkg::colsum_t   col_sum
);

	import bb3_pkg::*;

	col_t col_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
		end else if (ctl.shift) begin
			col_q <= col_in;
		end
	end

	always_comb begin
		col_sum = '0;
		for (int r = 0; r < 3; r++) begin
			if (ctl.rmask[r]) begin
				col_sum.red   = col_sum.red   + CSUM_W'(col_q[r].red);
				col_sum.green = col_sum.green + CSUM_W'(col_q[r].green);
				col_sum.blue  = col_sum.blue  + CSUM_W'(col_q[r].blue);
			end
		end
	end

	assign col_out = col_q;

endmodule

`default_nettype wire

// ===== rtl/box_blur_3x3_edge_aware.sv =====
// Top level of the frame-clipped 3x3 box blur on an RGB pixel stream
//
//  channel | signals                       | direction | payload
//  in      | in_valid / in_ready           | request   | bb3_in_t  (req_type, red, green, blue)
//  out     | out_valid / out_ready         | result    | bb3_out_t (out_red..blue, end_of_row/frame)
//  cfg     | cfg_valid / cfg_ready (=1)    | write     | cfg_index, cfg_data
//
//  A request that yields no result passes through line buffer read, window shift and masked
//  column sums; one that yields a result goes on to reciprocal multiply and output load.
//  The one-request sequencer takes no new request before the last is through; in_ready is high only between requests.
//  A stalled output holds the sequencer in its last step; the output register frees the
//  sequencer as soon as it loads. Reset clears window cells, counters and output valid and
//  sets the size to 640 x 480; line buffers are not cleared and need no clearing pass.
`default_nettype none
`include "box_blur_3x3_edge_aware_macros.svh"

module box_blur_3x3_edge_aware #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 4096
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  bb3_pkg::bb3_in_t             in_data,
	output logic                         out_valid,
	input  logic                         out_ready,
	output bb3_pkg::bb3_out_t            out_data,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  bb3_pkg::cfg_reg_t            cfg_index,
	input  logic [bb3_pkg::CFG_W-1:0]    cfg_data
);

	import bb3_pkg::*;

	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int CW    = COL_W + 1;
	localparam int RW    = (MAX_HEIGHT > 2) ? $clog2(MAX_HEIGHT) : 1;
	localparam int HCW   = RW + 1;
	localparam logic [RW-1:0] ROW_SAT = RW'(MAX_HEIGHT - 1);

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_SHIFT = 5'b00010,
		ST_SUM   = 5'b00100,
		ST_MUL   = 5'b01000,
		ST_PUSH  = 5'b10000
	} state_t;

	state_t state_q;

	logic [FW_W-1:0]  fw_q;
	logic [FH_W-1:0]  fh_q;
	logic [31:0]      w32;
	logic [31:0]      h32;
	logic [CW-1:0]    eff_w;
	logic [HCW-1:0]   eff_h;

	logic [COL_W-1:0] in_col_q;
	logic [COL_W-1:0] out_col_q;
	logic [COL_W-1:0] rd_col;
	logic [COL_W-1:0] col_q;
	logic [1:0]       in_row_q;
	logic [RW-1:0]    out_row_q;

	logic [CW-1:0]    col_inc;
	logic [CW-1:0]    ocol_inc;
	logic [HCW-1:0]   orow_inc;

	rgb_t                     pix_q;
	logic [$bits(rgb_t)-1:0]  upper_rd;
	logic [$bits(rgb_t)-1:0]  middle_rd;
	logic                     line_we;

	col_t      col_load [3];
	col_t      col_win  [3];
	colsum_t   col_sum  [3];
	cell_ctl_t cell_ctl;

	logic             in_acc;
	logic             out_load;
	logic             emit_q;
	logic             eor;
	logic             eof;
	logic [2:0]       cmask;
	logic [2:0]       rmask;
	logic [1:0]       ncv;
	logic [1:0]       nrv;
	logic [N_W-1:0]   n_cnt;
	logic [SUM_W-1:0] s_r;
	logic [SUM_W-1:0] s_g;
	logic [SUM_W-1:0] s_b;

	logic [X_W-1:0]     xr_q;
	logic [X_W-1:0]     xg_q;
	logic [X_W-1:0]     xb_q;
	logic [RECIP_W-1:0] recip_q;
	logic               eor_q;
	logic               eof_q;
	logic [PROD_W-1:0]  pr_q;
	logic [PROD_W-1:0]  pg_q;
	logic [PROD_W-1:0]  pb_q;
	bb3_out_t           out_q;
	logic               out_valid_q;

	always_comb begin
		w32 = 32'(fw_q);
		if (w32 == 32'd0) begin
			w32 = 32'd1;
		end
		if (w32 > 32'(MAX_WIDTH)) begin
			w32 = 32'(MAX_WIDTH);
		end
		eff_w = w32[CW-1:0];

		h32 = 32'(fh_q);
		if (h32 == 32'd0) begin
			h32 = 32'd1;
		end
		if (h32 > 32'(MAX_HEIGHT)) begin
			h32 = 32'(MAX_HEIGHT);
		end
		eff_h = h32[HCW-1:0];
	end

	assign in_acc   = in_valid && in_ready;
	assign rd_col   = ({1'b0, in_col_q} >= eff_w) ? '0 : in_col_q;
	assign col_inc  = {1'b0, col_q} + CW'(1);
	assign ocol_inc = {1'b0, out_col_q} + CW'(1);
	assign orow_inc = {1'b0, out_row_q} + HCW'(1);
	assign eor      = (ocol_inc >= eff_w);
	assign eof      = eor && (orow_inc >= eff_h);
	assign cmask    = {!eor, 1'b1, out_col_q != '0};
	assign rmask    = {orow_inc < eff_h, 1'b1, out_row_q != '0};
	assign ncv      = 2'($countones(cmask));
	assign nrv      = 2'($countones(rmask));
	assign n_cnt    = N_W'(ncv) * N_W'(nrv);
	assign line_we  = (state_q == ST_SHIFT);
	assign out_load = (state_q == ST_PUSH) && (!out_valid_q || out_ready);

	assign cell_ctl.shift = (state_q == ST_SHIFT);
	assign cell_ctl.rmask = rmask;

	bb3_ram #(
		.WIDTH($bits(rgb_t)),
		.DEPTH(MAX_WIDTH)
	) u_upper (
		.clk   (clk),
		.we    (line_we),
		.waddr (col_q),
		.wdata (middle_rd),
		.re    (in_acc),
		.raddr (rd_col),
		.rdata (upper_rd)
	);

	bb3_ram #(
		.WIDTH($bits(rgb_t)),
		.DEPTH(MAX_WIDTH)
	) u_middle (
		.clk   (clk),
		.we    (line_we),
		.waddr (col_q),
		.wdata (pix_q),
		.re    (in_acc),
		.raddr (rd_col),
		.rdata (middle_rd)
	);

	for (genvar c = 0; c < 3; c++) begin : g_cell
		if (c == 2) begin : g_feed
			assign col_load[c] = {pix_q, rgb_t'(middle_rd), rgb_t'(upper_rd)};
		end else begin : g_pass
			assign col_load[c] = col_win[c+1];
		end

		bb3_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (cell_ctl),
			.col_in  (col_load[c]),
			.col_out (col_win[c]),
			.col_sum (col_sum[c])
		);
	end

	always_comb begin
		s_r = '0;
		s_g = '0;
		s_b = '0;
		for (int c = 0; c < 3; c++) begin
			if (cmask[c]) begin
				s_r = s_r + SUM_W'(col_sum[c].red);
				s_g = s_g + SUM_W'(col_sum[c].green);
				s_b = s_b + SUM_W'(col_sum[c].blue);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			fw_q        <= FW_RESET;
			fh_q        <= FH_RESET;
			in_col_q    <= '0;
			in_row_q    <= '0;
			out_col_q   <= '0;
			out_row_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					REG_FRAME_WIDTH:  fw_q <= cfg_data[FW_W-1:0];
					REG_FRAME_HEIGHT: fh_q <= cfg_data[FH_W-1:0];
				endcase
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						state_q <= ST_SHIFT;
					end
				end
				ST_SHIFT: begin
					if (col_inc >= eff_w) begin
						in_col_q <= '0;
						if (in_row_q != 2'd2) begin
							in_row_q <= in_row_q + 2'd1;
						end
					end else begin
						in_col_q <= col_inc[COL_W-1:0];
					end
					state_q <= ST_SUM;
				end
				ST_SUM: begin
					if (emit_q) begin
						if (eof) begin
							in_col_q  <= '0;
							in_row_q  <= '0;
							out_col_q <= '0;
							out_row_q <= '0;
						end else if (eor) begin
							out_col_q <= '0;
							if (out_row_q < ROW_SAT) begin
								out_row_q <= out_row_q + RW'(1);
							end
						end else begin
							out_col_q <= ocol_inc[COL_W-1:0];
						end
						state_q <= ST_MUL;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_MUL: begin
					state_q <= ST_PUSH;
				end
				ST_PUSH: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			col_q <= rd_col;
			if (in_data.req_type == REQ_DRAIN) begin
				pix_q <= '0;
			end else begin
				pix_q <= {in_data.red, in_data.green, in_data.blue};
			end
		end
		if (state_q == ST_SHIFT) begin
			emit_q <= (in_row_q == 2'd2) || (in_row_q != 2'd0 && col_q != '0);
		end
		if (state_q == ST_SUM) begin
			xr_q    <= {s_r, 1'b0} + X_W'(n_cnt);
			xg_q    <= {s_g, 1'b0} + X_W'(n_cnt);
			xb_q    <= {s_b, 1'b0} + X_W'(n_cnt);
			recip_q <= recip(n_cnt);
			eor_q   <= eor;
			eof_q   <= eof;
		end
		if (state_q == ST_MUL) begin
			pr_q <= PROD_W'(xr_q) * PROD_W'(recip_q);
			pg_q <= PROD_W'(xg_q) * PROD_W'(recip_q);
			pb_q <= PROD_W'(xb_q) * PROD_W'(recip_q);
		end
		if (out_load) begin
			out_q.out_red      <= pr_q[RECIP_SHIFT +: CH_W];
			out_q.out_green    <= pg_q[RECIP_SHIFT +: CH_W];
			out_q.out_blue     <= pb_q[RECIP_SHIFT +: CH_W];
			out_q.end_of_row   <= eor_q;
			out_q.end_of_frame <= eof_q;
		end
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	`BB3_ASSERT_IMP(a_eof_has_eor, out_valid && out_data.end_of_frame, out_data.end_of_row, "end of frame without end of row")
	`BB3_ASSERT_NXT(a_no_emit_idle, state_q == ST_SUM && !emit_q, state_q == ST_IDLE, "request without result did not return to idle")
	`BB3_ASSERT_NXT(a_push_hold, state_q == ST_PUSH && out_valid && !out_ready, state_q == ST_PUSH, "result left the sequencer while output stalled")
	`BB3_ASSERT_NXT(a_eof_clear, state_q == ST_SUM && emit_q && eof, in_col_q == '0 && in_row_q == '0 && out_col_q == '0 && out_row_q == '0, "counters not cleared at end of frame")
	`BB3_ASSERT_IMP(a_recip_set, state_q == ST_MUL, recip_q != '0, "zero neighbor count reached the multiplier")

endmodule

`default_nettype wire

// ===== test/box_blur_3x3_edge_aware_tb.sv =====
// Self-checking testbench for the frame-clipped 3x3 box blur block
`timescale 1ns / 1ps

module testbench;
	import bb3_pkg::*;

	localparam int LINE_DEPTH  = 1024;
	localparam int ROWS_MAX    = 4096;
	localparam int ROW_CAP     = 4095;
	localparam int SETTLE      = 8;
	localparam int END_CYCLES  = 20;
	localparam int STALL_LIMIT = 1000;
	localparam int RANDOM_REQS = 480;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	bb3_in_t              in_data;
	logic                 out_valid;
	logic                 out_ready;
	bb3_out_t             out_data;
	logic                 cfg_valid;
	logic                 cfg_ready;
	cfg_reg_t             cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	// shadow state of the blur
	rgb_t                 upper_mem [LINE_DEPTH];
	rgb_t                 middle_mem [LINE_DEPTH];
	rgb_t                 win_cells [9];
	int                   in_row, in_col, out_row, out_col;
	logic [FW_W-1:0]      width_reg;
	logic [FH_W-1:0]      height_reg;
	bb3_out_t             pending_blur [$];

	bit                   frame_closed;
	bit                   no_idle;
	int                   reqs_sent;
	int                   fail_count;

	box_blur_3x3_edge_aware dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic int eff_w();
		if (width_reg == 0)
			return 1;
		if (width_reg > LINE_DEPTH)
			return LINE_DEPTH;
		return int'(width_reg);
	endfunction

	function automatic int eff_h();
		if (height_reg == 0)
			return 1;
		if (height_reg > ROWS_MAX)
			return ROWS_MAX;
		return int'(height_reg);
	endfunction

	task automatic log_fail(input string msg);
		if (fail_count < 10)
			$display("%s", msg);
		fail_count++;
	endtask

	task automatic blur_predict(input bb3_in_t req);
		int        w, h, col, orow, ocol, n, sr, sg, sb, c, r, k;
		bit        emit, eor, eof;
		bit [2:0]  col_ok, row_ok;
		rgb_t      pix, p;
		bb3_out_t  res;
		w = eff_w();
		h = eff_h();
		pix = '0;
		if (req.req_type == REQ_PIXEL) begin
			pix.red = req.red;
			pix.green = req.green;
			pix.blue = req.blue;
		end
		col = in_col;
		if (col >= w)
			col = 0;
		for (k = 0; k < 6; k++)
			win_cells[k] = win_cells[k + 3];
		win_cells[6] = upper_mem[col];
		win_cells[7] = middle_mem[col];
		win_cells[8] = pix;
		upper_mem[col] = middle_mem[col];
		middle_mem[col] = pix;
		emit = (in_row >= 2) || (in_row >= 1 && col >= 1);
		if (col + 1 >= w) begin
			in_col = 0;
			if (in_row < ROW_CAP)
				in_row++;
		end else begin
			in_col = col + 1;
		end
		if (emit) begin
			orow = out_row;
			ocol = out_col;
			eor = (ocol + 1 >= w);
			eof = eor && (orow + 1 >= h);
			col_ok = {!eor, 1'b1, ocol >= 1};
			row_ok = {orow + 1 < h, 1'b1, orow >= 1};
			n = 0;
			sr = 0;
			sg = 0;
			sb = 0;
			for (c = 0; c < 3; c++) begin
				for (r = 0; r < 3; r++) begin
					if (col_ok[c] && row_ok[r]) begin
						p = win_cells[c * 3 + r];
						sr += p.red;
						sg += p.green;
						sb += p.blue;
						n++;
					end
				end
			end
			res.out_red = CH_W'((2 * sr + n) / (2 * n));
			res.out_green = CH_W'((2 * sg + n) / (2 * n));
			res.out_blue = CH_W'((2 * sb + n) / (2 * n));
			res.end_of_row = eor;
			res.end_of_frame = eof;
			pending_blur.push_back(res);
			if (eof) begin
				in_row = 0;
				in_col = 0;
				out_row = 0;
				out_col = 0;
				frame_closed = 1'b1;
			end else if (eor) begin
				out_col = 0;
				if (out_row < ROW_CAP)
					out_row++;
			end else begin
				out_col = ocol + 1;
			end
		end
	endtask

	task automatic send_req(input bb3_in_t req);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= req;
		do @(posedge clk); while (in_ready !== 1'b1);
		blur_predict(req);
		reqs_sent++;
		@(negedge clk);
	endtask

	task automatic send_pixels(input int count);
		bb3_in_t req;
		repeat (count) begin
			req.req_type = ($urandom_range(0, 24) == 0) ? REQ_DRAIN : REQ_PIXEL;
			req.red = CH_W'($urandom_range(0, 255));
			req.green = CH_W'($urandom_range(0, 255));
			req.blue = CH_W'($urandom_range(0, 255));
			send_req(req);
		end
	endtask

	// finish the frame in progress, then send drain or pixel requests until its last result is due
	task automatic close_frame();
		bb3_in_t req;
		frame_closed = 1'b0;
		while (!frame_closed && in_row < eff_h())
			send_pixels(1);
		while (!frame_closed) begin
			req.req_type = $urandom_range(0, 1) ? REQ_DRAIN : REQ_PIXEL;
			req.red = CH_W'($urandom_range(0, 255));
			req.green = CH_W'($urandom_range(0, 255));
			req.blue = CH_W'($urandom_range(0, 255));
			send_req(req);
		end
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_blur.size() != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		if (idx == REG_FRAME_WIDTH)
			width_reg = data[FW_W-1:0];
		else
			height_reg = data[FH_W-1:0];
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_size(input int w, input int h);
		wait_idle();
		write_reg(REG_FRAME_WIDTH, CFG_W'(w));
		write_reg(REG_FRAME_HEIGHT, CFG_W'(h));
	endtask

	// run on the reset size, then shrink the frame while it is open
	task automatic test_default_size();
		no_idle = 1'b1;
		send_pixels(642);
		wait_idle();
		no_idle = 1'b0;
		write_reg(REG_FRAME_WIDTH, CFG_W'(4));
		write_reg(REG_FRAME_HEIGHT, CFG_W'(3));
		close_frame();
	endtask

	task automatic test_pixel_extremes();
		bb3_in_t pattern [12];
		pattern[0]  = {REQ_PIXEL, 8'hFF, 8'hFF, 8'hFF};
		pattern[1]  = {REQ_PIXEL, 8'h00, 8'h00, 8'h00};
		pattern[2]  = {REQ_PIXEL, 8'hAA, 8'h55, 8'h01};
		pattern[3]  = {REQ_DRAIN, 8'hFF, 8'hFF, 8'hFF};
		pattern[4]  = {REQ_PIXEL, 8'hFF, 8'h00, 8'h80};
		pattern[5]  = {REQ_PIXEL, 8'h01, 8'h01, 8'h01};
		pattern[6]  = {REQ_PIXEL, 8'h55, 8'hAA, 8'hFE};
		pattern[7]  = {REQ_PIXEL, 8'hFF, 8'hFF, 8'hFF};
		pattern[8]  = {REQ_PIXEL, 8'h00, 8'h00, 8'h01};
		pattern[9]  = {REQ_DRAIN, 8'h00, 8'h00, 8'h00};
		pattern[10] = {REQ_PIXEL, 8'hFF, 8'hFF, 8'hFF};
		pattern[11] = {REQ_PIXEL, 8'h7F, 8'h80, 8'h00};
		set_size(3, 3);
		frame_closed = 1'b0;
		foreach (pattern[i])
			send_req(pattern[i]);
		close_frame();
	endtask

	task automatic test_tiny_frames();
		// width field zero once the upper data bits are dropped
		set_size(13'h1800, 0);
		close_frame();
		close_frame();
		set_size(1, 5);
		close_frame();
		set_size(6, 1);
		close_frame();
		set_size(2, 2);
		close_frame();
	endtask

	// oversized width, then narrow the open frame
	task automatic test_width_limit();
		set_size(2047, 1);
		send_pixels(40);
		wait_idle();
		write_reg(REG_FRAME_WIDTH, CFG_W'(3));
		close_frame();
	endtask

	// oversized height, then shorten the open frame
	task automatic test_height_limit();
		no_idle = 1'b1;
		set_size(1, 8191);
		send_pixels(60);
		wait_idle();
		write_reg(REG_FRAME_HEIGHT, CFG_W'(64));
		close_frame();
		no_idle = 1'b0;
	endtask

	task automatic test_resize_in_frame();
		set_size(3, 6);
		send_pixels(10);
		wait_idle();
		write_reg(REG_FRAME_WIDTH, CFG_W'(7));
		write_reg(REG_FRAME_HEIGHT, CFG_W'(4));
		send_pixels(9);
		wait_idle();
		write_reg(REG_FRAME_WIDTH, CFG_W'(2));
		close_frame();
	endtask

	task automatic test_random_frames();
		int start, w, h;
		start = reqs_sent;
		while (reqs_sent - start < RANDOM_REQS) begin
			no_idle = ($urandom_range(0, 3) == 0);
			case ($urandom_range(0, 9))
				0:       w = 0;
				1, 2:    w = $urandom_range(9, 40);
				default: w = $urandom_range(1, 8);
			endcase
			h = ($urandom_range(0, 4) == 0) ? $urandom_range(8, 14) : $urandom_range(0, 7);
			set_size(w | ($urandom_range(0, 3) << FW_W), h);
			if ($urandom_range(0, 5) == 0) begin
				send_pixels($urandom_range(1, 3 * (eff_w() + 1)));
				wait_idle();
				if ($urandom_range(0, 1))
					write_reg(REG_FRAME_WIDTH, CFG_W'($urandom_range(0, 40)));
				else
					write_reg(REG_FRAME_HEIGHT, CFG_W'($urandom_range(0, 10)));
			end
			close_frame();
		end
		no_idle = 1'b0;
	endtask

	initial begin
		int k;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_FRAME_WIDTH;
		cfg_data = '0;
		for (k = 0; k < LINE_DEPTH; k++) begin
			upper_mem[k] = '0;
			middle_mem[k] = '0;
		end
		for (k = 0; k < 9; k++)
			win_cells[k] = '0;
		in_row = 0;
		in_col = 0;
		out_row = 0;
		out_col = 0;
		width_reg = FW_RESET;
		height_reg = FH_RESET;
		frame_closed = 1'b0;
		no_idle = 1'b0;
		reqs_sent = 0;
		fail_count = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_default_size();
		test_pixel_extremes();
		test_tiny_frames();
		test_width_limit();
		test_height_limit();
		test_resize_in_frame();
		test_random_frames();

		wait_idle();
		repeat (END_CYCLES) @(posedge clk);
		if (pending_blur.size() != 0)
			log_fail($sformatf("%0t: %0d blurred pixels never came out", $time,
				pending_blur.size()));
		if (fail_count == 0)
			$display("box_blur_3x3_edge_aware regression: pass");
		else
			$display("box_blur_3x3_edge_aware regression: fail");
		$finish;
	end

	initial begin
		int stall;
		out_ready = 1'b0;
		@(negedge clk);
		forever begin
			stall = no_idle ? 0 : $urandom_range(0, 5);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (out_valid !== 1'b1);
			@(negedge clk);
		end
	end

	always @(posedge clk) begin
		bb3_out_t want;
		if (arst_n && out_valid === 1'b1 && out_ready) begin
			if (pending_blur.size() == 0) begin
				log_fail($sformatf("%0t: blurred pixel %h with none pending", $time, out_data));
			end else begin
				want = pending_blur.pop_front();
				if (out_data.out_red !== want.out_red || out_data.out_green !== want.out_green
						|| out_data.out_blue !== want.out_blue
						|| out_data.end_of_row !== want.end_of_row
						|| out_data.end_of_frame !== want.end_of_frame)
					log_fail($sformatf({"%0t: want rgb %h %h %h eor %b eof %b,",
						" got rgb %h %h %h eor %b eof %b"}, $time,
						want.out_red, want.out_green, want.out_blue,
						want.end_of_row, want.end_of_frame,
						out_data.out_red, out_data.out_green, out_data.out_blue,
						out_data.end_of_row, out_data.end_of_frame));
			end
		end
	end

	// end the run when no channel moves for too long
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready)
					|| (cfg_valid && cfg_ready === 1'b1))
				quiet = 0;
			else
				quiet++;
		end
		$display("box_blur_3x3_edge_aware regression: fail");
		$finish;
	end

endmodule
